@@ rtl/core/ttf_pkg.sv @@
// Shared constants for the triangle tangent frame pipeline.
package ttf_pkg;

    localparam int INNER_FRAC = 30;
    localparam int UNIT_W     = INNER_FRAC + 2;
    localparam int NORM_W     = INNER_FRAC + 1;
    localparam int ROOT_W     = 32;
    localparam int SUM_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int DIV_W      = ROOT_W + 1;
    localparam int DOT_S_W    = 2 * UNIT_W - INNER_FRAC;
    localparam int TP_W       = DOT_S_W + 3;
    localparam int EDGE_KEEP  = 24;

endpackage

@@ rtl/core/ttf_cross.sv @@
// Two-stage pipelined signed cross product with a side bus.
module ttf_cross #(
    parameter int IN_W   = 25,
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [2:0][IN_W-1:0]        a,
    input  logic [2:0][IN_W-1:0]        b,
    input  logic [SIDE_W-1:0]           side_in,
    output logic [2:0][2*IN_W:0]        c,
    output logic [SIDE_W-1:0]           side_out
);

    localparam int PROD_W = 2 * IN_W;
    localparam int OUT_W  = 2 * IN_W + 1;

    logic signed [PROD_W-1:0] prod_reg [6];
    logic [2:0][OUT_W-1:0]    c_reg;
    logic [SIDE_W-1:0]        side1_reg;
    logic [SIDE_W-1:0]        side2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
        end
        else if (adv)
        begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= $signed(a[1]) * $signed(b[2]);
            prod_reg[1] <= $signed(a[2]) * $signed(b[1]);
            prod_reg[2] <= $signed(a[2]) * $signed(b[0]);
            prod_reg[3] <= $signed(a[0]) * $signed(b[2]);
            prod_reg[4] <= $signed(a[0]) * $signed(b[1]);
            prod_reg[5] <= $signed(a[1]) * $signed(b[0]);
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= OUT_W'(prod_reg[2*i]) - OUT_W'(prod_reg[2*i+1]);
            end
        end
    end

    assign c        = c_reg;
    assign side_out = side2_reg;

endmodule

@@ rtl/core/ttf_project.sv @@
// Four-stage projection of a unit direction off a unit normal.
module ttf_project #(
    parameter int SIDE_W = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic [2:0][ttf_pkg::UNIT_W-1:0]      du,
    input  logic [2:0][ttf_pkg::UNIT_W-1:0]      nu,
    input  logic [SIDE_W-1:0]                    side_in,
    output logic [2:0][ttf_pkg::TP_W-1:0]        tp,
    output logic [2:0][ttf_pkg::UNIT_W-1:0]      nu_out,
    output logic [SIDE_W-1:0]                    side_out
);

    localparam int UW   = ttf_pkg::UNIT_W;
    localparam int PW   = 2 * UW;
    localparam int SW   = ttf_pkg::DOT_S_W;
    localparam int SNW  = SW + UW;
    localparam int TW   = ttf_pkg::TP_W;
    localparam int FR   = ttf_pkg::INNER_FRAC;

    logic signed [PW-1:0]  prod_reg [3];
    logic signed [SNW-1:0] sn_reg [3];
    logic [SW-1:0]         s_reg;
    logic [2:0][UW-1:0]    du1_reg, du2_reg, du3_reg;
    logic [2:0][UW-1:0]    nu1_reg, nu2_reg, nu3_reg, nu4_reg;
    logic [2:0][TW-1:0]    tp_reg;
    logic [SIDE_W-1:0]     side_reg [4];
    logic signed [PW-1:0]  dot_next;

    assign dot_next = prod_reg[0] + prod_reg[1] + prod_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < 4; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= $signed(du[i]) * $signed(nu[i]);
                sn_reg[i]   <= $signed(s_reg) * $signed(nu2_reg[i]);
                tp_reg[i]   <= TW'($signed(du3_reg[i])) - TW'($signed(sn_reg[i][SNW-1:FR]));
            end
            s_reg   <= dot_next[PW-1:FR];
            du1_reg <= du;
            du2_reg <= du1_reg;
            du3_reg <= du2_reg;
            nu1_reg <= nu;
            nu2_reg <= nu1_reg;
            nu3_reg <= nu2_reg;
            nu4_reg <= nu3_reg;
        end
    end

    assign tp       = tp_reg;
    assign nu_out   = nu4_reg;
    assign side_out = side_reg[3];

endmodule

@@ rtl/core/ttf_unitize.sv @@
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
module ttf_unitize #(
    parameter int IN_W   = 51,
    parameter int SIDE_W = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic [2:0][IN_W-1:0]                 vec,
    input  logic [SIDE_W-1:0]                    side_in,
    output logic [2:0][ttf_pkg::UNIT_W-1:0]      unit,
    output logic                                 nonzero,
    output logic [SIDE_W-1:0]                    side_out
);

    localparam int FR       = ttf_pkg::INNER_FRAC;
    localparam int NW       = ttf_pkg::NORM_W;
    localparam int UW       = ttf_pkg::UNIT_W;
    localparam int RW       = ttf_pkg::ROOT_W;
    localparam int SUMW     = ttf_pkg::SUM_W;
    localparam int REMW     = ttf_pkg::REM_W;
    localparam int DVW      = ttf_pkg::DIV_W;
    localparam int POS_W    = (IN_W > 1) ? $clog2(IN_W) : 1;
    localparam int WIDE_W   = IN_W + FR;
    localparam int SQ_STEPS = RW;
    localparam int DV_STEPS = NW;
    localparam int CARRY_N  = SQ_STEPS + 3;

    // magnitude and leading-one stages
    logic [2:0][IN_W-1:0]  mag_next;
    logic [2:0][IN_W-1:0]  mag1_reg, mag2_reg;
    logic [2:0]            neg1_reg, neg2_reg;
    logic [SIDE_W-1:0]     side1_reg, side2_reg;
    logic [IN_W-1:0]       or_all;
    logic [POS_W-1:0]      pos_next, pos2_reg;
    logic                  nz2_reg;
    logic [2:0][NW-1:0]    m_next;

    // carried through scaling, squares and root
    logic [2:0][NW-1:0]    cm_reg   [CARRY_N];
    logic [2:0]            cneg_reg [CARRY_N];
    logic                  cnz_reg  [CARRY_N];
    logic [SIDE_W-1:0]     cside_reg[CARRY_N];
    logic [2*NW-1:0]       sq_reg   [3];

    // root chain
    logic [SUMW-1:0]       rx_reg   [SQ_STEPS+1];
    logic [REMW-1:0]       rem_reg  [SQ_STEPS+1];
    logic [RW-1:0]         root_reg [SQ_STEPS+1];

    // divider chain
    logic [2:0][RW-1:0]    dr_reg   [DV_STEPS];
    logic [2:0][NW-1:0]    dq_reg   [DV_STEPS];
    logic [RW-1:0]         dlen_reg [DV_STEPS];
    logic [2:0]            dneg_reg [DV_STEPS];
    logic                  dnz_reg  [DV_STEPS];
    logic [SIDE_W-1:0]     dside_reg[DV_STEPS];

    logic [2:0][UW-1:0]    unit_reg;
    logic                  nz_reg;
    logic [SIDE_W-1:0]     side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = vec[i][IN_W-1] ? IN_W'(-vec[i]) : vec[i];
        end
    end

    assign or_all = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];

    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (or_all[i])
            begin
                pos_next = POS_W'(i);
            end
        end
    end

    always_comb
    begin
        logic [WIDE_W-1:0] wide;
        for (int i = 0; i < 3; i++)
        begin
            wide      = {mag2_reg[i], {FR{1'b0}}} >> pos2_reg;
            m_next[i] = wide[NW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
            for (int k = 0; k < CARRY_N; k++)
            begin
                cside_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            side1_reg    <= side_in;
            side2_reg    <= side1_reg;
            cside_reg[0] <= side2_reg;
            for (int k = 1; k < CARRY_N; k++)
            begin
                cside_reg[k] <= cside_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg    <= mag_next;
            for (int i = 0; i < 3; i++)
            begin
                neg1_reg[i] <= vec[i][IN_W-1];
                sq_reg[i]   <= cm_reg[0][i] * cm_reg[0][i];
            end
            mag2_reg    <= mag1_reg;
            neg2_reg    <= neg1_reg;
            pos2_reg    <= pos_next;
            nz2_reg     <= |or_all;
            cm_reg[0]   <= m_next;
            cneg_reg[0] <= neg2_reg;
            cnz_reg[0]  <= nz2_reg;
            for (int k = 1; k < CARRY_N; k++)
            begin
                cm_reg[k]   <= cm_reg[k-1];
                cneg_reg[k] <= cneg_reg[k-1];
                cnz_reg[k]  <= cnz_reg[k-1];
            end
            rx_reg[0]   <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_root
        logic [REMW+1:0] rr;
        logic [REMW+1:0] trial;
        logic            ge;

        assign rr    = {rem_reg[k], rx_reg[k][SUMW-1:SUMW-2]};
        assign trial = {2'b00, root_reg[k], 2'b01};
        assign ge    = rr >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rx_reg[k+1]   <= {rx_reg[k][SUMW-3:0], 2'b00};
                rem_reg[k+1]  <= ge ? REMW'(rr - trial) : rr[REMW-1:0];
                root_reg[k+1] <= {root_reg[k][RW-2:0], ge};
            end
        end
    end

    for (genvar j = 0; j < DV_STEPS; j++)
    begin : g_div
        logic [2:0][RW-1:0] r_src;
        logic [2:0][NW-1:0] q_src;
        logic [RW-1:0]      len_src;
        logic [2:0]         neg_src;
        logic               nz_src;
        logic [SIDE_W-1:0]  side_src;
        logic [2:0][DVW-1:0] t;
        logic [2:0]          ge;

        if (j == 0)
        begin : g_first
            assign len_src  = root_reg[SQ_STEPS];
            assign neg_src  = cneg_reg[CARRY_N-1];
            assign nz_src   = cnz_reg[CARRY_N-1];
            assign side_src = cside_reg[CARRY_N-1];
            assign q_src    = '0;
            assign r_src    = '0;
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign t[i] = DVW'(cm_reg[CARRY_N-1][i]);
            end
        end
        else
        begin : g_next
            assign len_src  = dlen_reg[j-1];
            assign neg_src  = dneg_reg[j-1];
            assign nz_src   = dnz_reg[j-1];
            assign side_src = dside_reg[j-1];
            assign q_src    = dq_reg[j-1];
            assign r_src    = dr_reg[j-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign t[i] = {r_src[i], 1'b0};
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_cmp
            assign ge[i] = t[i] >= {1'b0, len_src};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dside_reg[j] <= '0;
            end
            else if (adv)
            begin
                dside_reg[j] <= side_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dr_reg[j][i] <= ge[i] ? RW'(t[i] - {1'b0, len_src}) : t[i][RW-1:0];
                    dq_reg[j][i] <= {q_src[i][NW-2:0], ge[i]};
                end
                dlen_reg[j] <= len_src;
                dneg_reg[j] <= neg_src;
                dnz_reg[j]  <= nz_src;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (adv)
        begin
            side_reg <= dside_reg[DV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                unit_reg[i] <= dneg_reg[DV_STEPS-1][i] ? UW'(-{1'b0, dq_reg[DV_STEPS-1][i]})
                                                       : UW'(dq_reg[DV_STEPS-1][i]);
            end
            nz_reg <= dnz_reg[DV_STEPS-1];
        end
    end

    assign unit     = unit_reg;
    assign nonzero  = nz_reg;
    assign side_out = side_reg;

endmodule

@@ rtl/core/triangle_tangent_frame.sv @@
// Top level: triangle edges to unit tangent and binormal, fully pipelined.
//
// channel | signals                              | beat
// input   | in_valid, in_ready, p0_*..p2_*       | one triangle
// output  | out_valid, out_ready, tangent_*,     | one tangent frame
//         | binormal_*, degenerate               |
//
// One triangle enters per cycle while the output is not stalled; the pipeline depth
// is set by the three chained normalizers (32 root steps and 31 divide steps each).
// Reset clears every valid bit and the side-bus registers; other payload registers are not reset.
// A stalled output beat freezes the whole pipeline in place; nothing moves or drops.
module triangle_tangent_frame #(
    parameter int COORD_WIDTH    = 24,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COORD_WIDTH-1:0]      p0_x,
    input  logic [COORD_WIDTH-1:0]      p0_y,
    input  logic [COORD_WIDTH-1:0]      p0_z,
    input  logic [COORD_WIDTH-1:0]      p1_x,
    input  logic [COORD_WIDTH-1:0]      p1_y,
    input  logic [COORD_WIDTH-1:0]      p1_z,
    input  logic [COORD_WIDTH-1:0]      p2_x,
    input  logic [COORD_WIDTH-1:0]      p2_y,
    input  logic [COORD_WIDTH-1:0]      p2_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [UNIT_FRAC_BITS+1:0]   tangent_x,
    output logic [UNIT_FRAC_BITS+1:0]   tangent_y,
    output logic [UNIT_FRAC_BITS+1:0]   tangent_z,
    output logic [UNIT_FRAC_BITS+1:0]   binormal_x,
    output logic [UNIT_FRAC_BITS+1:0]   binormal_y,
    output logic [UNIT_FRAC_BITS+1:0]   binormal_z,
    output logic                        degenerate
);

    localparam int UW      = ttf_pkg::UNIT_W;
    localparam int E_SHIFT = (COORD_WIDTH > ttf_pkg::EDGE_KEEP)
                             ? COORD_WIDTH - ttf_pkg::EDGE_KEEP : 0;
    localparam int E_W     = COORD_WIDTH - E_SHIFT + 1;
    localparam int N_W     = 2 * E_W + 1;
    localparam int B_W     = 2 * UW + 1;
    localparam int OUT_W   = UNIT_FRAC_BITS + 2;
    localparam int OUT_SH  = ttf_pkg::INNER_FRAC - UNIT_FRAC_BITS;
    localparam logic [UW-1:0] HALF = (UW'(1) << OUT_SH) >> 1;
    localparam int CN_SIDE = 3 * E_W + 1;
    localparam int VS_SIDE = 3 * UW + 2;

    logic adv;

    logic [2:0][COORD_WIDTH-1:0] p0, p1, p2;
    logic [2:0][E_W-1:0]         e1_next, e2_next;
    logic [2:0][E_W-1:0]         e1_reg, e2_reg, d_reg;
    logic                        v0_reg;

    logic [2:0][N_W-1:0]         n_vec;
    logic [CN_SIDE-1:0]          cn_side;
    logic [2:0][E_W-1:0]         d_vec;

    logic [2:0][UW-1:0]          nu, du;
    logic                        n_nz, d_nz;
    logic                        n_side, d_side;

    logic [2:0][ttf_pkg::TP_W-1:0] tp;
    logic [2:0][UW-1:0]          pj_nu;
    logic [1:0]                  pj_side;

    logic [2:0][UW-1:0]          tu;
    logic                        t_nz;
    logic [VS_SIDE-1:0]          ut_side;
    logic [2:0][UW-1:0]          ut_nu;

    logic [2:0][B_W-1:0]         b_vec;
    logic [VS_SIDE-1:0]          cb_side;

    logic [2:0][UW-1:0]          bu;
    logic                        b_nz;
    logic [VS_SIDE-1:0]          ub_side;
    logic [2:0][UW-1:0]          tu_fin;
    logic                        ok_fin;

    logic [2:0][OUT_W-1:0]       tan_next, bin_next;
    logic [2:0][OUT_W-1:0]       tan_reg, bin_reg;
    logic                        degen_reg;
    logic                        out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    assign p0 = {p0_z, p0_y, p0_x};
    assign p1 = {p1_z, p1_y, p1_x};
    assign p2 = {p2_z, p2_y, p2_x};

    always_comb
    begin
        logic signed [COORD_WIDTH:0] diff1;
        logic signed [COORD_WIDTH:0] diff2;
        for (int i = 0; i < 3; i++)
        begin
            diff1      = (COORD_WIDTH+1)'($signed(p1[i])) - (COORD_WIDTH+1)'($signed(p0[i]));
            diff2      = (COORD_WIDTH+1)'($signed(p2[i])) - (COORD_WIDTH+1)'($signed(p0[i]));
            e1_next[i] = E_W'(diff1 >>> E_SHIFT);
            e2_next[i] = E_W'(diff2 >>> E_SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            d_reg  <= (p0 == p1) ? e2_next : e1_next;
        end
    end

    ttf_cross #(
        .IN_W   (E_W),
        .SIDE_W (CN_SIDE)
    ) u_cross_n (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .a        (e1_reg),
        .b        (e2_reg),
        .side_in  ({d_reg, v0_reg}),
        .c        (n_vec),
        .side_out (cn_side)
    );

    assign d_vec = cn_side[CN_SIDE-1:1];

    ttf_unitize #(
        .IN_W   (N_W),
        .SIDE_W (1)
    ) u_unit_n (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vec      (n_vec),
        .side_in  (cn_side[0]),
        .unit     (nu),
        .nonzero  (n_nz),
        .side_out (n_side)
    );

    ttf_unitize #(
        .IN_W   (E_W),
        .SIDE_W (1)
    ) u_unit_d (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vec      (d_vec),
        .side_in  (cn_side[0]),
        .unit     (du),
        .nonzero  (d_nz),
        .side_out (d_side)
    );

    ttf_project #(
        .SIDE_W (2)
    ) u_project (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .du       (du),
        .nu       (nu),
        .side_in  ({n_nz & d_nz, n_side & d_side}),
        .tp       (tp),
        .nu_out   (pj_nu),
        .side_out (pj_side)
    );

    ttf_unitize #(
        .IN_W   (ttf_pkg::TP_W),
        .SIDE_W (VS_SIDE)
    ) u_unit_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vec      (tp),
        .side_in  ({pj_nu, pj_side}),
        .unit     (tu),
        .nonzero  (t_nz),
        .side_out (ut_side)
    );

    assign ut_nu = ut_side[VS_SIDE-1:2];

    ttf_cross #(
        .IN_W   (UW),
        .SIDE_W (VS_SIDE)
    ) u_cross_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .a        (tu),
        .b        (ut_nu),
        .side_in  ({tu, ut_side[1] & t_nz, ut_side[0]}),
        .c        (b_vec),
        .side_out (cb_side)
    );

    ttf_unitize #(
        .IN_W   (B_W),
        .SIDE_W (VS_SIDE)
    ) u_unit_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vec      (b_vec),
        .side_in  (cb_side),
        .unit     (bu),
        .nonzero  (b_nz),
        .side_out (ub_side)
    );

    assign tu_fin = ub_side[VS_SIDE-1:2];
    assign ok_fin = ub_side[1] & b_nz;

    always_comb
    begin
        logic [UW-1:0] mag;
        logic [UW-1:0] rnd;
        for (int i = 0; i < 3; i++)
        begin
            mag         = tu_fin[i][UW-1] ? UW'(-tu_fin[i]) : tu_fin[i];
            rnd         = (mag + HALF) >> OUT_SH;
            rnd         = tu_fin[i][UW-1] ? UW'(-rnd) : rnd;
            tan_next[i] = ok_fin ? rnd[OUT_W-1:0] : '0;
            mag         = bu[i][UW-1] ? UW'(-bu[i]) : bu[i];
            rnd         = (mag + HALF) >> OUT_SH;
            rnd         = bu[i][UW-1] ? UW'(-rnd) : rnd;
            bin_next[i] = ok_fin ? rnd[OUT_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ub_side[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tan_reg   <= tan_next;
            bin_reg   <= bin_next;
            degen_reg <= !ok_fin;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tangent_x  = tan_reg[0];
    assign tangent_y  = tan_reg[1];
    assign tangent_z  = tan_reg[2];
    assign binormal_x = bin_reg[0];
    assign binormal_y = bin_reg[1];
    assign binormal_z = bin_reg[2];
    assign degenerate = degen_reg;

endmodule
